### rtl/lpr_pkg.sv
// ---------------------------------------------------------------------------
// lpr_pkg
// Shared widths, beat types and cell link types for the LRU page replacement
// block.
// ---------------------------------------------------------------------------
package lpr_pkg;

	localparam int PAGE_W  = 8;
	localparam int CFG_W   = 5;
	localparam int FAULT_W = 16;

	localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = CFG_W'(4);

	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [CFG_W-1:0]   frame_count_t;
	typedef logic [FAULT_W-1:0] fault_t;

	typedef struct packed {
		page_t page_number;
		logic  last_reference;
	} lpr_in_beat_t;

	typedef struct packed {
		logic   hit;
		logic   evicted_valid;
		page_t  evicted_page;
		fault_t fault_total;
		logic   final_res;
	} lpr_out_beat_t;

	// control broadcast to every cell
	typedef struct packed {
		logic  en;
		page_t page;
		logic  hit;
		logic  full;
	} lpr_ctl_t;

	// data handed from one cell to the next one down the stack
	typedef struct packed {
		page_t page;
		logic  valid;
		logic  found;
	} lpr_link_t;

	// per-cell status toward the top level
	typedef struct packed {
		logic  hit;
		page_t evict_page;
	} lpr_stat_t;

endpackage

### rtl/lpr_if.sv
// ---------------------------------------------------------------------------
// lpr_if
// Valid/ready channels of the LRU page replacement block: reference input,
// result output and frame count configuration.
// ---------------------------------------------------------------------------
interface lpr_in_if import lpr_pkg::*; ();
	logic         valid;
	logic         ready;
	lpr_in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lpr_out_if import lpr_pkg::*; ();
	logic          valid;
	logic          ready;
	lpr_out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lpr_cfg_if import lpr_pkg::*; ();
	logic         valid;
	logic         ready;
	frame_count_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/lru_page_replacement.sv
// ---------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement over a row of frame cells kept in recency order.
// ---------------------------------------------------------------------------
// Each req beat is one page reference and yields one rsp beat in the next
// cycle. All frame cells compare the page in parallel and the stack shifts
// in the same cycle, so a new reference is taken every cycle; the single
// output register holds one result, and a stalled rsp holds off req until
// that result is taken. frame_count (1..FRAMES, 0 reads as 1, larger values
// as FRAMES) must be written on cfg only while no reference is in flight;
// the block does not enforce it. Fault total counts since reset, saturates.
module lru_page_replacement import lpr_pkg::*; #(
	parameter int FRAMES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	lpr_in_if.sink     req,
	lpr_out_if.source  rsp,
	lpr_cfg_if.sink    cfg
);

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int NW = ((IW > CFG_W) ? IW : CFG_W) + 1;

	frame_count_t  frame_count_q;
	fault_t        fault_q;
	lpr_out_beat_t out_q;
	logic          out_valid_q;

	lpr_ctl_t      ctl;
	lpr_link_t     link [FRAMES+1];
	lpr_stat_t     stat [FRAMES];
	logic [FRAMES-1:0] valid_vec;
	logic [FRAMES-1:0] hit_vec;
	page_t         evict_page;
	logic [NW-1:0] fc_ext;
	logic [NW-1:0] n_m1;
	logic          accept;
	fault_t        fault_next;

	assign cfg.ready = 1'b1;
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RESET;
		end else if (cfg.valid) begin
			frame_count_q <= cfg.data;
		end
	end

	// deepest frame index in use
	assign fc_ext = NW'(frame_count_q);
	always_comb begin
		if (fc_ext == '0) begin
			n_m1 = '0;
		end else if (fc_ext > NW'(FRAMES)) begin
			n_m1 = NW'(FRAMES - 1);
		end else begin
			n_m1 = fc_ext - NW'(1);
		end
	end

	assign link[0].page  = req.data.page_number;
	assign link[0].valid = 1'b1;
	assign link[0].found = 1'b0;

	genvar g;
	generate
		for (g = 0; g < FRAMES; g++) begin : g_cell
			logic nxt_valid;
			if (g == FRAMES - 1) begin : g_tail
				assign nxt_valid = 1'b0;
			end else begin : g_mid
				assign nxt_valid = link[g+2].valid;
			end
			lpr_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.up         (link[g]),
				.down_valid (nxt_valid),
				.down       (link[g+1]),
				.stat       (stat[g])
			);
			assign valid_vec[g] = link[g+1].valid;
			assign hit_vec[g]   = stat[g].hit;
		end
	endgenerate

	always_comb begin
		evict_page = '0;
		for (int i = 0; i < FRAMES; i++) begin
			evict_page = evict_page | stat[i].evict_page;
		end
	end

	assign ctl.en   = accept;
	assign ctl.page = req.data.page_number;
	assign ctl.hit  = |hit_vec;
	assign ctl.full = valid_vec[n_m1[IW-1:0]];

	always_comb begin
		fault_next = fault_q;
		if (!ctl.hit && (fault_q != '1)) begin
			fault_next = fault_q + FAULT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fault_q     <= fault_next;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.hit           <= ctl.hit;
			out_q.evicted_valid <= !ctl.hit && ctl.full;
			out_q.evicted_page  <= (!ctl.hit && ctl.full) ? evict_page : '0;
			out_q.fault_total   <= fault_next;
			out_q.final_res     <= req.data.last_reference;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

### rtl/lpr_cell.sv
// ---------------------------------------------------------------------------
// lpr_cell
// One entry of the recency stack: holds a page and its valid bit, compares
// against the referenced page and takes its upper neighbor's entry on a push.
// ---------------------------------------------------------------------------
module lpr_cell import lpr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lpr_ctl_t  ctl,
	input  lpr_link_t up,
	input  logic      down_valid,
	output lpr_link_t down,
	output lpr_stat_t stat
);

	page_t page_q;
	logic  valid_q;
	logic  match;
	logic  shift;

	assign match = valid_q && (page_q == ctl.page);

	// hit: shift down to the hit entry; miss full: overwrite deepest valid;
	// miss with room: push into the first free entry
	always_comb begin
		if (ctl.hit) begin
			shift = !up.found;
		end else if (ctl.full) begin
			shift = valid_q;
		end else begin
			shift = up.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.en && shift) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && shift) begin
			page_q <= up.page;
		end
	end

	assign down.page       = page_q;
	assign down.valid      = valid_q;
	assign down.found      = up.found | match;
	assign stat.hit        = match;
	assign stat.evict_page = (valid_q && !down_valid) ? page_q : '0;

endmodule
